@@ rtl/sokl_pkg.sv @@
// Package for the self-organizing key list: item structs, mode and status
// codes, and the control word broadcast to the key cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sokl_pkg;

  // Item modes
  localparam logic [2:0] MODE_FRONT_INS = 3'd0;
  localparam logic [2:0] MODE_ORDER_INS = 3'd1;
  localparam logic [2:0] MODE_FIND      = 3'd2;
  localparam logic [2:0] MODE_DELETE    = 3'd3;
  localparam logic [2:0] MODE_MOVE_FRNT = 3'd4;
  localparam logic [2:0] MODE_TRANSPOSE = 3'd5;
  localparam logic [2:0] MODE_READ      = 3'd6;

  // Result status codes
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_AT_FRONT  = 3'd3;
  localparam logic [2:0] ST_BEYOND    = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] key;
    logic [3:0]         read_position;
  } sokl_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         found_position;
    logic signed [31:0] key_out;
    logic [4:0]         entry_count;
  } sokl_out_t;

  // Update applied by every cell on the commit cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_MOVE_FRONT,
    OP_SWAP
  } sokl_op_e;

  // Broadcast from the controller to all cells
  typedef struct packed {
    logic               sample;   // latch compare flags against cmp_key
    logic signed [31:0] cmp_key;
    logic               commit;   // apply op this cycle
    sokl_op_e           op;
    logic               front;    // insert point forced to position 0
    logic signed [31:0] new_key;
  } sokl_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/self_organizing_key_list_top.sv @@
// Top level of the self-organizing key list: item control, result register
// and the row of key cells. Depends on sokl_pkg and sokl_cell.
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries one item (mode, key,
//   read position). Output channel out_valid_o / out_ready_i returns one
//   result per item (status, position, key read, entry count).
//   Each item is accepted, then committed: on the accept edge every cell
//   latches its equal / less-or-equal flags; on the commit edge, once the
//   output register is free, the neighbor chains settle the first match and
//   insert point, every cell shifts in one step, and the result is written
//   to the output register, raising out_valid_o. No new item is accepted
//   until the current one has committed.
//   A result waiting in the output register does not block the next accept;
//   if the receiver stalls, the following item holds in the cells until
//   the output register frees up, and in_ready_o stays low meanwhile.
//   Reset empties the list (count zero) and clears both valid flags; key
//   storage is not cleared since entries at or beyond the count are never
//   read.
`timescale 1ns / 1ps
`default_nettype none

module self_organizing_key_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sokl_pkg::sokl_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sokl_pkg::sokl_out_t out_item_o
);
  import sokl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic                busy_q, busy_d;
  logic                out_valid_q, out_valid_d;
  logic [CW-1:0]       count_q, count_d;
  sokl_in_t            req_q;
  sokl_out_t           out_q, out_d;
  logic                accept, commit;
  sokl_ctrl_t          ctrl;
  sokl_op_e            op;

  logic [CAPACITY-1:0][31:0] cell_key;
  logic [CAPACITY:0]         seen_c, run_c, past_c;
  logic [CAPACITY-1:0]       first_c, ins_c;

  logic          found, full, rpos_ok;
  logic [IW-1:0] match_pos, ins_pos;
  logic [31:0]   read_key;
  logic [31:0]   pos_ext, cnt_ext;
  logic [IW-1:0] res_pos;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q;
  assign commit     = busy_q && (!out_valid_q || out_ready_i);

  // Cell broadcast
  always_comb begin
    ctrl.sample  = accept;
    ctrl.cmp_key = in_item_i.key;
    ctrl.commit  = commit;
    ctrl.op      = commit ? op : OP_NONE;
    ctrl.front   = (req_q.mode == MODE_FRONT_INS);
    ctrl.new_key = req_q.key;
  end

  // Row of cells
  assign seen_c[0] = 1'b0;
  assign run_c[0]  = 1'b1;
  assign past_c[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_key, right_key;
    logic               first_right;
    if (g == 0) begin : g_l0
      assign left_key = '0;
    end else begin : g_ln
      assign left_key = cell_key[g-1];
    end
    if (g == CAPACITY - 1) begin : g_rl
      assign right_key   = '0;
      assign first_right = 1'b0;
    end else begin : g_rn
      assign right_key   = cell_key[g+1];
      assign first_right = first_c[g+1];
    end
    sokl_cell #(
      .CAPACITY(CAPACITY),
      .IDX     (g)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .key_left_i   (left_key),
      .key_right_i  (right_key),
      .seen_i       (seen_c[g]),
      .run_i        (run_c[g]),
      .past_i       (past_c[g]),
      .first_right_i(first_right),
      .key_o        (cell_key[g]),
      .seen_o       (seen_c[g+1]),
      .run_o        (run_c[g+1]),
      .past_o       (past_c[g+1]),
      .first_o      (first_c[g]),
      .ins_o        (ins_c[g])
    );
  end

  // Position and read buses
  always_comb begin
    match_pos = '0;
    ins_pos   = '0;
    read_key  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_c[i]) match_pos = match_pos | IW'(i);
      if (ins_c[i])   ins_pos   = ins_pos | IW'(i);
      if (32'(i) == 32'(req_q.read_position)) read_key = read_key | cell_key[i];
    end
  end

  assign found   = seen_c[CAPACITY];
  assign full    = 32'(count_q) >= 32'(CAPACITY);
  assign rpos_ok = 32'(req_q.read_position) < 32'(count_q);

  // Decode the item into a status and a cell operation
  always_comb begin
    op            = OP_NONE;
    count_d       = count_q;
    res_pos       = '0;
    out_d.status  = ST_DONE;
    out_d.key_out = '0;
    unique case (req_q.mode)
      MODE_FRONT_INS, MODE_ORDER_INS: begin
        if (full) begin
          out_d.status = ST_FULL;
        end else begin
          op      = OP_INSERT;
          res_pos = ins_pos;
          count_d = count_q + CW'(1);
        end
      end
      MODE_FIND: begin
        if (!found) out_d.status = ST_NOT_FOUND;
        else        res_pos = match_pos;
      end
      MODE_DELETE: begin
        if (!found) begin
          out_d.status = ST_NOT_FOUND;
        end else begin
          op      = OP_DELETE;
          res_pos = match_pos;
          count_d = count_q - CW'(1);
        end
      end
      MODE_MOVE_FRNT, MODE_TRANSPOSE: begin
        if (!found) begin
          out_d.status = ST_NOT_FOUND;
        end else if (match_pos == '0) begin
          out_d.status = ST_AT_FRONT;
        end else begin
          op      = (req_q.mode == MODE_MOVE_FRNT) ? OP_MOVE_FRONT : OP_SWAP;
          res_pos = match_pos;
        end
      end
      MODE_READ: begin
        if (rpos_ok) out_d.key_out = read_key;
        else         out_d.status  = ST_BEYOND;
      end
      default: op = OP_NONE;
    endcase
    pos_ext              = 32'(res_pos);
    cnt_ext              = 32'(count_d);
    out_d.found_position = pos_ext[3:0];
    out_d.entry_count    = cnt_ext[4:0];
  end

  // Handshake state
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (commit) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
    end
    if (accept) busy_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (commit) count_q <= count_d;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_item_i;
    if (commit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/sokl_cell.sv @@
// One list position: holds a key, latches its compare flags and shifts
// keys to or from its neighbors. Depends on sokl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sokl_cell #(
  parameter int CAPACITY = 16,
  parameter int IDX      = 0
) (
  input  logic                           clk_i,
  input  sokl_pkg::sokl_ctrl_t           ctrl_i,
  input  logic [$clog2(CAPACITY+1)-1:0]  count_i,
  input  logic signed [31:0]             key_left_i,
  input  logic signed [31:0]             key_right_i,
  input  logic                           seen_i,      // match at an earlier position
  input  logic                           run_i,       // all earlier entries <= key, not a front insert
  input  logic                           past_i,      // insert point lies earlier
  input  logic                           first_right_i,
  output logic signed [31:0]             key_o,
  output logic                           seen_o,
  output logic                           run_o,
  output logic                           past_o,
  output logic                           first_o,
  output logic                           ins_o
);
  import sokl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] key_q, key_d;
  logic               eq_q, le_q;
  logic               occ, cond, ins_here;

  // Compare flags, taken when the item is accepted
  assign occ = CW'(IDX) < count_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sample) begin
      eq_q <= occ && (key_q == ctrl_i.cmp_key);
      le_q <= occ && (key_q <= ctrl_i.cmp_key);
    end
  end

  // Neighbor chains
  assign first_o  = eq_q && !seen_i;
  assign seen_o   = seen_i || eq_q;
  assign cond     = le_q && !ctrl_i.front;
  assign ins_here = run_i && !cond;
  assign run_o    = run_i && cond;
  assign past_o   = past_i || ins_here;
  assign ins_o    = ins_here;

  // Key update
  always_comb begin
    key_d = key_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (ins_here)    key_d = ctrl_i.new_key;
        else if (past_i) key_d = key_left_i;
      end
      OP_DELETE: begin
        if (first_o || seen_i) key_d = key_right_i;
      end
      OP_MOVE_FRONT: begin
        if (IDX == 0)     key_d = ctrl_i.new_key;
        else if (!seen_i) key_d = key_left_i;
      end
      OP_SWAP: begin
        if (first_o)            key_d = key_left_i;
        else if (first_right_i) key_d = ctrl_i.new_key;
      end
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

`default_nettype wire
